### rtl/pidc_pkg.sv
// Package for the PID controller step core: shared constants, register
// indexes and control option bit positions. Depends on nothing.
package pidc_pkg;

	localparam int DEFAULT_VALUE_WIDTH   = 32;
	localparam int DEFAULT_FRACTION_BITS = 16;

	// Port field widths fixed by the word formats.
	localparam int IO_W       = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Filter factors are Q0.16, so a blend shifts by sixteen.
	localparam int ALPHA_SHIFT = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DBAND   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OPTIONS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RBAND   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER  = 3'd7;

	localparam int OPT_INCR  = 0;
	localparam int OPT_TRAP  = 1;
	localparam int OPT_VRATE = 2;
	localparam int OPT_DMEAS = 3;
	localparam int OPT_DFILT = 4;
	localparam int OPT_AWIND = 5;
	localparam int OPT_DBAND = 6;
	localparam int OPT_OFILT = 7;

endpackage

### rtl/pidc_if.sv
// Valid/ready channel interfaces for the PID controller step core.
// Depends on pidc_pkg for the field widths.
interface pidc_in_if import pidc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic signed [IO_W-1:0] measured_value;
	logic signed [IO_W-1:0] target_value;

	modport source (output valid, output measured_value, output target_value, input ready);
	modport sink (input valid, input measured_value, input target_value, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic signed [IO_W-1:0] drive_value;
	logic                   output_clamped;

	modport source (output valid, output drive_value, output output_clamped, input ready);
	modport sink (input valid, input drive_value, input output_clamped, output ready);
endinterface

### rtl/pidc_mul.sv
// Shared sign-magnitude multiplier for the PID core: four half-width partial
// products, then a floor shift by FB or sixteen bits. Depends on pidc_pkg.
module pidc_mul import pidc_pkg::*; #(
	parameter int OPW = 33,
	parameter int FB = DEFAULT_FRACTION_BITS,
	localparam int HALF = (OPW + 1) / 2,
	localparam int RW = 4 * HALF + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  shift16,
	input  logic signed [OPW-1:0] op_a,
	input  logic signed [OPW-1:0] op_b,
	output logic                  done,
	output logic signed [RW-1:0]  result
);

	localparam int MW = 2 * HALF;
	localparam int PW = 2 * MW;
	localparam logic [PW-1:0] MASK_FB = {{(PW-FB){1'b0}}, {FB{1'b1}}};
	localparam logic [PW-1:0] MASK_16 = {{(PW-ALPHA_SHIFT){1'b0}}, {ALPHA_SHIFT{1'b1}}};

	typedef enum logic [1:0] {M_IDLE, M_MAC, M_RND, M_SGN} mstate_t;

	mstate_t       state_q;
	logic [MW-1:0] ma_q, mb_q;
	logic          neg_q, sh16_q, done_q;
	logic [1:0]    cnt_q;
	logic [PW-1:0] acc_q, q_q;
	logic signed [RW-1:0] result_q;

	logic [MW:0]     a_ext, b_ext, a_neg, b_neg;
	logic [MW-1:0]   mag_a, mag_b;
	logic [HALF-1:0] ah, bh;
	logic [MW-1:0]   pp;
	logic [PW-1:0]   pp_ext, pp_sh;
	logic [1:0]      pos;
	logic [PW-1:0]   q_sel;
	logic            rem_nz;

	always_comb begin
		a_ext = {{(MW+1-OPW){op_a[OPW-1]}}, op_a};
		b_ext = {{(MW+1-OPW){op_b[OPW-1]}}, op_b};
		a_neg = (MW+1)'(~a_ext + 1'b1);
		b_neg = (MW+1)'(~b_ext + 1'b1);
		mag_a = op_a[OPW-1] ? a_neg[MW-1:0] : a_ext[MW-1:0];
		mag_b = op_b[OPW-1] ? b_neg[MW-1:0] : b_ext[MW-1:0];
		ah = cnt_q[0] ? ma_q[MW-1:HALF] : ma_q[HALF-1:0];
		bh = cnt_q[1] ? mb_q[MW-1:HALF] : mb_q[HALF-1:0];
		pp = ah * bh;
		pp_ext = {{(PW-MW){1'b0}}, pp};
		pos = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		unique case (pos)
			2'd0: pp_sh = pp_ext;
			2'd1: pp_sh = pp_ext << HALF;
			2'd2: pp_sh = pp_ext << MW;
			default: pp_sh = pp_ext;
		endcase
		q_sel = sh16_q ? (acc_q >> ALPHA_SHIFT) : (acc_q >> FB);
		rem_nz = sh16_q ? |(acc_q & MASK_16) : |(acc_q & MASK_FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			ma_q <= '0;
			mb_q <= '0;
			neg_q <= 1'b0;
			sh16_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			q_q <= '0;
			result_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						ma_q <= mag_a;
						mb_q <= mag_b;
						neg_q <= op_a[OPW-1] ^ op_b[OPW-1];
						sh16_q <= shift16;
						cnt_q <= '0;
						acc_q <= '0;
						state_q <= M_MAC;
					end
				end
				M_MAC: begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= M_RND;
				end
				M_RND: begin
					// Magnitude is truncated, so a negative result rounds down by one more.
					q_q <= q_sel + PW'(neg_q && rem_nz);
					state_q <= M_SGN;
				end
				M_SGN: begin
					result_q <= neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

### rtl/pid_controller_step_core.sv
// PID controller step core, top level. Depends on pidc_pkg, the channel
// interfaces in pidc_if and the shared multiplier pidc_mul.
//
// Usage: each word on the sample channel carries a measurement and a target
// in signed fixed point; the core answers each with exactly one word on the
// result channel, the clamped drive value and a flag that tells whether the
// output limit acted. Eight registers on the plain write port (wr_en,
// wr_index, wr_data) hold gains, limits, bands, option bits and filter factors;
// write them only while the core is idle.
// Flow: one word at a time. A word in the dead band skips the products and
// posts its result from the error state. Otherwise the sequencer runs three
// products (proportional, integral, derivative) on the shared multiplier plus
// bookkeeping states; variable-rate integration adds a bit-serial divider and
// one product, and each low-pass filter adds one product. The next word is
// taken only after the result has been taken.
// The single multiplier and the one-bit-per-cycle divider set the pace.
// sample.ready is high only while the core is idle; a result stays on the
// result channel until taken, and a stalled receiver holds the core busy.
// Reset clears all registers, the history and the channels.
module pid_controller_step_core import pidc_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
	parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pidc_in_if.sink               sample,
	pidc_out_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int W = VALUE_WIDTH;
	localparam int FB = FRACTION_BITS;
	// The filter blends multiply a difference of two values, which needs W + 1 bits.
	localparam int OPW0 = (W + 2 > FB + 2) ? W + 2 : FB + 2;
	localparam int OPW = (OPW0 > IO_W + 1) ? OPW0 : IO_W + 1;
	localparam int HALF = (OPW + 1) / 2;
	localparam int RW = 4 * HALF + 1;
	// Working width for sums, compares against 32-bit limits and inputs.
	localparam int AW = ((W > IO_W) ? W : IO_W) + 3;
	localparam int CNT_W = $clog2(FB + 1);

	localparam logic signed [AW-1:0] VMAX_A = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [AW-1:0] VMIN_A = ~VMAX_A;
	localparam logic signed [RW-1:0] VMAX_R = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [RW-1:0] VMIN_R = ~VMAX_R;

	typedef logic signed [W-1:0] val_t;
	typedef logic signed [AW-1:0] wide_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_P, ST_I, ST_DIV, ST_VRMUL, ST_D, ST_DF,
		ST_INTEG, ST_DRIVE, ST_OF, ST_CLAMP, ST_OUT
	} state_t;

	function automatic wide_t xa(input val_t v);
		return {{(AW-W){v[W-1]}}, v};
	endfunction

	function automatic wide_t zx32(input logic [IO_W-1:0] v);
		return {{(AW-IO_W){1'b0}}, v};
	endfunction

	function automatic val_t sat_a(input wide_t x);
		if (x > VMAX_A) return VMAX_A[W-1:0];
		if (x < VMIN_A) return VMIN_A[W-1:0];
		return x[W-1:0];
	endfunction

	function automatic val_t sat_r(input logic signed [RW-1:0] x);
		if (x > VMAX_R) return VMAX_R[W-1:0];
		if (x < VMIN_R) return VMIN_R[W-1:0];
		return x[W-1:0];
	endfunction

	function automatic val_t sadd(input val_t a, input val_t b);
		return sat_a(xa(a) + xa(b));
	endfunction

	function automatic val_t ssub(input val_t a, input val_t b);
		return sat_a(xa(a) - xa(b));
	endfunction

	function automatic wide_t abs_a(input val_t v);
		wide_t t;
		t = xa(v);
		return (t < 0) ? -t : t;
	endfunction

	function automatic logic same_sign(input val_t x, input val_t y);
		return (x != '0) && (y != '0) && (x[W-1] == y[W-1]);
	endfunction

	function automatic logic signed [OPW-1:0] op_v(input val_t v);
		return {{(OPW-W){v[W-1]}}, v};
	endfunction

	function automatic logic signed [OPW-1:0] op_k(input logic [IO_W-1:0] k);
		return {{(OPW-IO_W){k[IO_W-1]}}, k};
	endfunction

	// Configuration registers.
	logic [IO_W-1:0]       kp_q, ki_q, kd_q, filt_q;
	logic [CFG_DATA_W-1:0] lim_q, rband_q;
	logic [IO_W-2:0]       band_q;
	logic [7:0]            opt_q;

	// Sequencer and datapath registers.
	state_t           state_q;
	logic             mul_wait_q;
	val_t             m_q, r_q, e_q, p_q, step_q, d_q, drive_q;
	logic [IO_W:0]    rem_q;
	logic [FB:0]      ratio_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IO_W-1:0]  out_drive_q;
	logic             out_clamped_q, out_valid_q;

	// Controller history.
	val_t last_err_q, older_err_q, last_meas_q, older_meas_q;
	val_t isum_q, last_drive_q, last_deriv_q;

	// Shared multiplier hookup.
	logic                  mul_start, mul_sh16, mul_done;
	logic signed [OPW-1:0] mul_a, mul_b;
	logic signed [RW-1:0]  mul_res;
	val_t                  mul_w;
	wide_t                 mul_lo;

	logic incr, trap, vrate, dmeas, dfilt, awind, dband, ofilt;
	val_t e_new, dop, half_sum, tsum, tout, isum_new, drive_new, clamp_val;
	wide_t ae_new, ae, atout, olim_a, ilim_a, ba_a, bb_a, num_a, hsum;
	logic db_hit, vr_cond, vr_div, aw_zero, hi_i, lo_i, hi_o, lo_o;
	logic div_ge;
	logic [IO_W:0] div_sub;
	val_t in_m, in_r;

	pidc_mul #(.OPW(OPW), .FB(FB)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.shift16(mul_sh16),
		.op_a(mul_a),
		.op_b(mul_b),
		.done(mul_done),
		.result(mul_res)
	);

	always_comb begin
		incr = opt_q[OPT_INCR];
		trap = opt_q[OPT_TRAP];
		vrate = opt_q[OPT_VRATE];
		dmeas = opt_q[OPT_DMEAS];
		dfilt = opt_q[OPT_DFILT];
		awind = opt_q[OPT_AWIND];
		dband = opt_q[OPT_DBAND];
		ofilt = opt_q[OPT_OFILT];

		in_m = sat_a({{(AW-IO_W){sample.measured_value[IO_W-1]}}, sample.measured_value});
		in_r = sat_a({{(AW-IO_W){sample.target_value[IO_W-1]}}, sample.target_value});

		olim_a = zx32(lim_q[IO_W-1:0]);
		ilim_a = zx32(lim_q[CFG_DATA_W-1:IO_W]);
		ba_a = zx32(rband_q[IO_W-1:0]);
		bb_a = zx32(rband_q[CFG_DATA_W-1:IO_W]);

		e_new = ssub(r_q, m_q);
		ae_new = abs_a(e_new);
		db_hit = dband && (ae_new < {{(AW-IO_W+1){1'b0}}, band_q});
		ae = abs_a(e_q);

		// Variable-rate integration: keep, scale or drop the step.
		vr_cond = vrate && same_sign(e_q, isum_q) && (ae > bb_a);
		vr_div = (ae <= ba_a + bb_a) && (rband_q[IO_W-1:0] != '0);
		num_a = ba_a + bb_a - ae;
		div_ge = rem_q >= {1'b0, rband_q[IO_W-1:0]};
		div_sub = div_ge ? rem_q - {1'b0, rband_q[IO_W-1:0]} : rem_q;

		hsum = (xa(e_q) + xa(last_err_q)) >>> 1;
		half_sum = hsum[W-1:0];

		if (incr) begin
			if (dmeas) dop = ssub(ssub(sadd(last_meas_q, last_meas_q), m_q), older_meas_q);
			else dop = sadd(ssub(e_q, sadd(last_err_q, last_err_q)), older_err_q);
		end else begin
			if (dmeas) dop = ssub(last_meas_q, m_q);
			else dop = ssub(e_q, last_err_q);
		end

		// Integral update: the bare step in incremental form; in positional form, clamp or anti-windup.
		tsum = sadd(isum_q, step_q);
		tout = sadd(sadd(p_q, isum_q), d_q);
		atout = abs_a(tout);
		aw_zero = awind && (atout > olim_a) && same_sign(e_q, isum_q);
		hi_i = xa(tsum) > ilim_a;
		lo_i = xa(tsum) < -ilim_a;
		priority if (incr) isum_new = step_q;
		else if (hi_i) isum_new = sat_a(ilim_a);
		else if (lo_i) isum_new = sat_a(-ilim_a);
		else if (aw_zero) isum_new = isum_q;
		else isum_new = tsum;

		drive_new = incr ? sadd(last_drive_q, sadd(sadd(p_q, isum_q), d_q))
			: sadd(sadd(p_q, isum_q), d_q);

		hi_o = xa(drive_q) > olim_a;
		lo_o = xa(drive_q) < -olim_a;
		priority if (hi_o) clamp_val = sat_a(olim_a);
		else if (lo_o) clamp_val = sat_a(-olim_a);
		else clamp_val = drive_q;

		mul_w = sat_r(mul_res);
		mul_lo = $signed(mul_res[AW-1:0]);

		mul_a = op_k(kp_q);
		mul_b = op_v(e_q);
		mul_sh16 = 1'b0;
		unique case (state_q)
			ST_P: begin
				mul_a = op_k(kp_q);
				mul_b = op_v(incr ? ssub(e_q, last_err_q) : e_q);
			end
			ST_I: begin
				mul_a = op_k(ki_q);
				mul_b = op_v((!incr && trap) ? half_sum : e_q);
			end
			ST_VRMUL: begin
				mul_a = op_v(step_q);
				mul_b = {{(OPW-FB-1){1'b0}}, ratio_q};
			end
			ST_D: begin
				mul_a = op_k(kd_q);
				mul_b = op_v(dop);
			end
			ST_DF: begin
				// A blend is y + floor((x - y) * alpha / 2^16).
				mul_a = OPW'(xa(d_q) - xa(last_deriv_q));
				mul_b = {{(OPW-ALPHA_SHIFT){1'b0}}, filt_q[ALPHA_SHIFT-1:0]};
				mul_sh16 = 1'b1;
			end
			ST_OF: begin
				mul_a = OPW'(xa(drive_q) - xa(last_drive_q));
				mul_b = {{(OPW-ALPHA_SHIFT){1'b0}}, filt_q[IO_W-1:ALPHA_SHIFT]};
				mul_sh16 = 1'b1;
			end
			default: begin
				mul_a = op_k(kp_q);
				mul_b = op_v(e_q);
			end
		endcase
		mul_start = !mul_wait_q && ((state_q == ST_P) || (state_q == ST_I) ||
			(state_q == ST_VRMUL) || (state_q == ST_D) || (state_q == ST_DF) ||
			(state_q == ST_OF));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			lim_q <= '0;
			band_q <= '0;
			opt_q <= '0;
			rband_q <= '0;
			filt_q <= '0;
			state_q <= ST_IDLE;
			mul_wait_q <= 1'b0;
			m_q <= '0;
			r_q <= '0;
			e_q <= '0;
			p_q <= '0;
			step_q <= '0;
			d_q <= '0;
			drive_q <= '0;
			rem_q <= '0;
			ratio_q <= '0;
			cnt_q <= '0;
			out_drive_q <= '0;
			out_clamped_q <= 1'b0;
			out_valid_q <= 1'b0;
			last_err_q <= '0;
			older_err_q <= '0;
			last_meas_q <= '0;
			older_meas_q <= '0;
			isum_q <= '0;
			last_drive_q <= '0;
			last_deriv_q <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_KP: kp_q <= wr_data[IO_W-1:0];
					REG_KI: ki_q <= wr_data[IO_W-1:0];
					REG_KD: kd_q <= wr_data[IO_W-1:0];
					REG_LIMITS: lim_q <= wr_data;
					REG_DBAND: band_q <= wr_data[IO_W-2:0];
					REG_OPTIONS: opt_q <= wr_data[7:0];
					REG_RBAND: rband_q <= wr_data;
					REG_FILTER: filt_q <= wr_data[IO_W-1:0];
				endcase
			end
			if (mul_start) mul_wait_q <= 1'b1;
			if (mul_done) mul_wait_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						m_q <= in_m;
						r_q <= in_r;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					e_q <= e_new;
					if (db_hit) begin
						// Dead band: held drive (incr) or 0; shift only error/meas history.
						out_drive_q <= incr ? IO_W'(xa(last_drive_q)) : '0;
						out_clamped_q <= 1'b0;
						out_valid_q <= 1'b1;
						older_err_q <= last_err_q;
						last_err_q <= e_new;
						older_meas_q <= last_meas_q;
						last_meas_q <= m_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_P;
					end
				end
				ST_P: begin
					if (mul_done) begin
						p_q <= mul_w;
						state_q <= ST_I;
					end
				end
				ST_I: begin
					if (mul_done) begin
						if (vr_cond && vr_div) begin
							step_q <= mul_w;
							rem_q <= num_a[IO_W:0];
							ratio_q <= '0;
							cnt_q <= CNT_W'(FB);
							state_q <= ST_DIV;
						end else begin
							step_q <= vr_cond ? '0 : mul_w;
							state_q <= ST_D;
						end
					end
				end
				ST_DIV: begin
					// Restoring division, one quotient bit per cycle.
					ratio_q <= {ratio_q[FB-1:0], div_ge};
					rem_q <= {div_sub[IO_W-1:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_VRMUL;
				end
				ST_VRMUL: begin
					if (mul_done) begin
						step_q <= mul_w;
						state_q <= ST_D;
					end
				end
				ST_D: begin
					if (mul_done) begin
						d_q <= mul_w;
						state_q <= dfilt ? ST_DF : ST_INTEG;
					end
				end
				ST_DF: begin
					if (mul_done) begin
						d_q <= sat_a(xa(last_deriv_q) + mul_lo);
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					isum_q <= isum_new;
					state_q <= ST_DRIVE;
				end
				ST_DRIVE: begin
					drive_q <= drive_new;
					state_q <= ofilt ? ST_OF : ST_CLAMP;
				end
				ST_OF: begin
					if (mul_done) begin
						drive_q <= sat_a(xa(last_drive_q) + mul_lo);
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					out_drive_q <= IO_W'(xa(clamp_val));
					out_clamped_q <= hi_o || lo_o;
					out_valid_q <= 1'b1;
					older_err_q <= last_err_q;
					last_err_q <= e_q;
					older_meas_q <= last_meas_q;
					last_meas_q <= m_q;
					last_drive_q <= clamp_val;
					last_deriv_q <= d_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.drive_value = out_drive_q;
	assign result.output_clamped = out_clamped_q;

endmodule

### rtl/pidc_checker.sv
// Port-level checker for the PID controller step core, with its bind.
// Depends on pidc_pkg and on the top level's channel ports.
module pidc_checker import pidc_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [IO_W-1:0] drive_value,
	input logic            output_clamped
);

	// The core works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("core ready right after taking a word");

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("core ready while a result is pending");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result shown in the cycle after acceptance");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(drive_value) && $stable(output_clamped)))
		else $error("stalled result changed or dropped");

endmodule

bind pid_controller_step_core pidc_checker u_pidc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.drive_value(result.drive_value),
	.output_clamped(result.output_clamped)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_controller_step_core: a directed table and then randomized
// phases, each result checked against a typed value or an in-bench predictor of the PID step.
// Depends on pidc_pkg and the channel interfaces in pidc_if.
module tb;
	import pidc_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 5000;
	// Settling time before a register write, longer than the slowest word.
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES = 16;
	localparam int WORDS_PER_PHASE = 125;

	typedef struct {
		logic [31:0] drive;
		logic        clamped;
	} drive_word_t;

	typedef struct {
		logic signed [31:0] meas;
		logic signed [31:0] targ;
		bit                 typed;
		logic [31:0]        drive;
		logic               clamped;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	pidc_in_if  sample();
	pidc_out_if result();

	pid_controller_step_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow copy of the register file and of the controller history.
	logic [63:0] reg_shadow [8];
	longint hist_err1, hist_err2, hist_meas1, hist_meas2;
	longint integ_acc, prev_drive, prev_deriv, prev_prop;

	drive_word_t expected_drive_q [$];
	int   mismatches;
	bit   idle_on;
	int   quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat_val(longint x);
		if (x > VMAX) return VMAX;
		if (x < VMIN) return VMIN;
		return x;
	endfunction

	// Fixed-point product: full precision, floor shift, then saturate.
	function automatic longint q_mul(longint a, longint b);
		logic signed [127:0] pa, pb, pr;
		pa = a;
		pb = b;
		pr = (pa * pb) >>> 16;
		if (pr > VMAX) return VMAX;
		if (pr < VMIN) return VMIN;
		return longint'(pr);
	endfunction

	function automatic longint low_pass(longint x, longint y, logic [15:0] alpha);
		longint w;
		w = alpha;
		return (x * w + y * (65536 - w)) >>> 16;
	endfunction

	function automatic bit same_sign(longint x, longint y);
		return (x > 0 && y > 0) || (x < 0 && y < 0);
	endfunction

	// One controller step on the shadow state; returns the expected result word.
	function automatic drive_word_t pid_predict(logic signed [31:0] meas_in,
			logic signed [31:0] targ_in);
		drive_word_t w;
		longint m, e, ae, kp, ki, kd, olim, ilim, band, ba, bb;
		longint p, stp, d, drv, tsum, tout, num, ratio;
		logic [7:0] opt;
		bit incr;
		m = meas_in;
		kp = longint'($signed(reg_shadow[REG_KP][31:0]));
		ki = longint'($signed(reg_shadow[REG_KI][31:0]));
		kd = longint'($signed(reg_shadow[REG_KD][31:0]));
		olim = longint'({32'd0, reg_shadow[REG_LIMITS][31:0]});
		ilim = longint'({32'd0, reg_shadow[REG_LIMITS][63:32]});
		band = longint'(reg_shadow[REG_DBAND]);
		opt = reg_shadow[REG_OPTIONS][7:0];
		ba = longint'({32'd0, reg_shadow[REG_RBAND][31:0]});
		bb = longint'({32'd0, reg_shadow[REG_RBAND][63:32]});
		incr = opt[OPT_INCR];
		e = sat_val(longint'(targ_in) - m);
		ae = (e < 0) ? -e : e;
		w.clamped = 1'b0;

		// Inside the dead band only the error and measurement history move.
		if (opt[OPT_DBAND] && ae < band) begin
			drv = incr ? prev_drive : 0;
			hist_err2 = hist_err1;
			hist_err1 = e;
			hist_meas2 = hist_meas1;
			hist_meas1 = m;
			w.drive = drv[31:0];
			return w;
		end

		p = q_mul(kp, incr ? sat_val(e - hist_err1) : e);
		stp = q_mul(ki, e);
		if (!incr && opt[OPT_TRAP])
			stp = q_mul(ki, (e + hist_err1) >>> 1);
		if (opt[OPT_VRATE] && same_sign(e, integ_acc) && ae > bb) begin
			if (ae <= ba + bb && ba > 0) begin
				num = ba + bb - ae;
				ratio = (num << 16) / ba;
				stp = q_mul(stp, ratio);
			end else begin
				stp = 0;
			end
		end

		if (incr) begin
			integ_acc = stp;
			if (opt[OPT_DMEAS])
				d = q_mul(kd, sat_val(sat_val(sat_val(2 * hist_meas1) - m) - hist_meas2));
			else
				d = q_mul(kd, sat_val(sat_val(e - sat_val(2 * hist_err1)) + hist_err2));
		end else begin
			if (opt[OPT_DMEAS]) d = q_mul(kd, sat_val(hist_meas1 - m));
			else d = q_mul(kd, sat_val(e - hist_err1));
		end
		if (opt[OPT_DFILT]) d = low_pass(d, prev_deriv, reg_shadow[REG_FILTER][15:0]);

		if (incr) begin
			drv = sat_val(prev_drive + sat_val(sat_val(p + integ_acc) + d));
		end else begin
			if (opt[OPT_AWIND]) begin
				tsum = sat_val(integ_acc + stp);
				tout = sat_val(sat_val(p + integ_acc) + d);
				if (tout < 0) tout = -tout;
				if (tout > olim && same_sign(e, integ_acc)) stp = 0;
				if (tsum > ilim) begin
					stp = 0;
					integ_acc = sat_val(ilim);
				end else if (tsum < -ilim) begin
					stp = 0;
					integ_acc = sat_val(-ilim);
				end
				integ_acc = sat_val(integ_acc + stp);
			end else begin
				integ_acc = sat_val(integ_acc + stp);
				if (integ_acc > ilim) integ_acc = sat_val(ilim);
				else if (integ_acc < -ilim) integ_acc = sat_val(-ilim);
			end
			drv = sat_val(sat_val(p + integ_acc) + d);
		end

		if (opt[OPT_OFILT]) drv = low_pass(drv, prev_drive, reg_shadow[REG_FILTER][31:16]);
		if (drv > olim) begin
			drv = sat_val(olim);
			w.clamped = 1'b1;
		end else if (drv < -olim) begin
			drv = sat_val(-olim);
			w.clamped = 1'b1;
		end

		hist_err2 = hist_err1;
		hist_err1 = e;
		hist_meas2 = hist_meas1;
		hist_meas1 = m;
		prev_drive = drv;
		prev_deriv = d;
		prev_prop = p;
		w.drive = drv[31:0];
		return w;
	endfunction

	// Register write on the plain port; the shadow keeps only the implemented bits.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		logic [63:0] mask;
		case (idx)
			REG_LIMITS, REG_RBAND: mask = 64'hFFFF_FFFF_FFFF_FFFF;
			REG_DBAND: mask = 64'h7FFF_FFFF;
			REG_OPTIONS: mask = 64'hFF;
			default: mask = 64'hFFFF_FFFF;
		endcase
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		reg_shadow[idx] = val & mask;
	endtask

	// Send one sample word. When the word is taken, the predictor runs and the
	// expected result joins the queue. A typed row overrides the predicted value
	// but still advances the shadow state.
	task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] targ,
			bit typed, logic [31:0] drive, logic clamped);
		int gap;
		drive_word_t w;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.measured_value <= meas;
		sample.target_value <= targ;
		do @(posedge clk); while (!sample.ready);
		w = pid_predict(meas, targ);
		if (typed) begin
			w.drive = drive;
			w.clamped = clamped;
		end
		expected_drive_q.push_back(w);
	endtask

	// Drop valid, then wait until every expected word has come back and the
	// core has had time to settle.
	task automatic drain_results();
		sample.valid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'd0;
			default: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
		endcase
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(0, 32'h20_0000);
		endcase
	endfunction

	// Random configuration of all eight registers, with extremes in fixed phases.
	task automatic configure_phase(int phase);
		logic [7:0] opts;
		logic [31:0] dband;
		opts = 8'($urandom());
		if (phase == 0) opts = 8'h00;
		if (phase == 1) opts = 8'hFF;
		if (phase == 2) opts = 8'hFE;
		case ($urandom_range(0, 3))
			0: dband = 32'h7FFF_FFFF;
			1: dband = $urandom() >> 1;
			default: dband = $urandom_range(0, 32'h8000);
		endcase
		write_reg(REG_KP, (phase == 1) ? 64'h7FFF_FFFF : {32'd0, rand_gain()});
		write_reg(REG_KI, (phase == 1) ? 64'h8000_0000 : {32'd0, rand_gain()});
		write_reg(REG_KD, {32'd0, rand_gain()});
		write_reg(REG_LIMITS, (phase == 1) ? 64'hFFFF_FFFF_FFFF_FFFF :
			{rand_limit(), rand_limit()});
		write_reg(REG_DBAND, {32'd0, dband});
		write_reg(REG_OPTIONS, {56'd0, opts});
		write_reg(REG_RBAND, {32'($urandom_range(0, 32'h40000)),
			32'($urandom_range(0, 32'h40000))});
		write_reg(REG_FILTER, {32'd0, $urandom()});
	endtask

	// Directed rows: after reset every gain and limit is zero, so the drive is zero
	// and the clamp flag stays low whatever the input. The later rows run with
	// every option but the incremental form on and are checked by the predictor.
	stim_row_t directed_rows [] = '{
		'{32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'h0, 1'b0},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'h0, 1'b0},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'h0, 1'b0},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'h0, 1'b0},
		'{32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'h0, 1'b0},
		'{32'shFFFF_FFFF, 32'sh0000_0001, 1'b1, 32'h0, 1'b0},
		'{32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 32'h0, 1'b0},
		'{32'sh0001_0000, 32'sh0003_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0002_0000, 32'sh0003_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0003_0000, 32'sh0003_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0002_FFF0, 32'sh0003_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0000_0000, 32'sh0100_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0000_0000, 32'sh0100_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh0100_0000, 32'sh0000_0000, 1'b0, 32'h0, 1'b0},
		'{32'shFFFF_0000, 32'sh0000_0000, 1'b0, 32'h0, 1'b0},
		'{32'sh1234_5678, 32'sh1234_5678, 1'b0, 32'h0, 1'b0}
	};

	// Sink side: when gaps are on, the receiver drops ready at random before each word, and
	// compares what it takes with the oldest expectation.
	initial begin : result_checker
		int gap;
		drive_word_t w;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!(result.valid && result.ready));
			if (expected_drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: drive %h clamped %b",
						result.drive_value, result.output_clamped);
			end else begin
				w = expected_drive_q.pop_front();
				if (result.drive_value !== w.drive || result.output_clamped !== w.clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected drive %h clamped %b, got %h %b",
							w.drive, w.clamped, result.drive_value, result.output_clamped);
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic signed [31:0] base, meas, targ;
		mismatches = 0;
		idle_on = 1'b1;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		sample.valid <= 1'b0;
		sample.measured_value <= '0;
		sample.target_value <= '0;
		for (int i = 0; i < 8; i++) reg_shadow[i] = '0;
		hist_err1 = 0; hist_err2 = 0; hist_meas1 = 0; hist_meas2 = 0;
		integ_acc = 0; prev_drive = 0; prev_deriv = 0; prev_prop = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The switch to every option but the incremental form, with a
		// dead band of one sixteenth and moderate gains, comes after the last typed row.
		foreach (directed_rows[i]) begin
			if (i == 7) begin
				drain_results();
				write_reg(REG_KP, 64'h0001_0000);
				write_reg(REG_KI, 64'h0000_8000);
				write_reg(REG_KD, 64'h0000_4000);
				write_reg(REG_LIMITS, 64'h0008_0000_0010_0000);
				write_reg(REG_DBAND, 64'h0000_1000);
				write_reg(REG_OPTIONS, 64'hFE);
				write_reg(REG_RBAND, 64'h0002_0000_0004_0000);
				write_reg(REG_FILTER, 64'h8000_C000);
			end
			send_sample(directed_rows[i].meas, directed_rows[i].targ,
				directed_rows[i].typed, directed_rows[i].drive, directed_rows[i].clamped);
		end

		// Random phases. Most words track a slowly moving target with a small
		// error so that integral, filters and band logic see realistic loops;
		// the rest are full-range and corner values.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			configure_phase(ph);
			idle_on = (ph % 4 != 3);
			base = $urandom_range(0, 32'h80000) - 32'h40000;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// Hold the sender once until every outstanding result is back.
				if (ph == 5 && n == 60) begin
					sample.valid <= 1'b0;
					while (expected_drive_q.size() != 0) @(posedge clk);
				end
				case ($urandom_range(0, 9))
					0: begin
						meas = $urandom();
						targ = $urandom();
					end
					1: begin
						meas = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
						targ = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					end
					default: begin
						base = base + 32'($urandom_range(0, 32'h2000)) - 32'h1000;
						targ = base;
						meas = base + 32'($urandom_range(0, 32'h60000)) - 32'h30000;
					end
				endcase
				send_sample(meas, targ, 1'b0, 32'h0, 1'b0);
			end
		end

		sample.valid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_drive_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/pidc_pkg.sv
rtl/pidc_if.sv
rtl/pidc_mul.sv
rtl/pid_controller_step_core.sv
rtl/pidc_checker.sv
tb/tb.sv
